@@ hdl/mrrc_pkg.sv @@
package mrrc_pkg;

  localparam int unsigned MaxRegisters = 8;
  localparam int unsigned RegIdxW      = (MaxRegisters > 1) ? $clog2(MaxRegisters) : 1;
  localparam int unsigned RegCntW      = 4;
  localparam int unsigned ByteCntW     = 5;
  localparam int unsigned CfgDataW     = 7;

  localparam logic [7:0]  SlaveAddr    = 8'hFE;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [ByteCntW-1:0] ExcTailBytes = ByteCntW'(3);

  typedef enum logic [1:0] {
    ACT_ARM     = 2'd0,
    ACT_BYTE    = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ADDR    = 3'd1,
    ST_CODE    = 3'd2,
    ST_EXC     = 3'd3,
    ST_CRC     = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_CODE  = 3'd2,
    PH_EXC   = 3'd3,
    PH_BODY  = 3'd4,
    PH_CRCLO = 3'd5,
    PH_CRCHI = 3'd6
  } phase_e;

  typedef enum logic {
    CFG_FUNC_CODE = 1'b0,
    CFG_REG_COUNT = 1'b1
  } cfg_index_e;

endpackage

@@ hdl/mrrc_crc_update.sv @@
module mrrc_crc_update (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);
  import mrrc_pkg::*;

  // reflected crc-16, one byte per call, bit by bit
  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

@@ hdl/modbus_rtu_register_response_checker_top.sv @@
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// in       | in_valid_i / in_stall_o    | action_i, rx_byte_i
// out      | out_valid_o / out_stall_i  | status_o, reg_index_o, reg_value_o, last_o
// cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// an input transaction is handled in the cycle it is taken; its single result, if any,
// sits in the output register on the next cycle. a crc match plays out the stored
// registers from the register file one per unstalled cycle; input is stalled throughout.
// otherwise one input transaction per cycle while the output register drains.
// rst_ni clears phase, counters and crc; the register file is not reset.
module modbus_rtu_register_response_checker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [7:0]                    rx_byte_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [2:0]                    reg_index_o,
  output logic [15:0]                   reg_value_o,
  output logic                          last_o,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [mrrc_pkg::CfgDataW-1:0] cfg_data_i
);
  import mrrc_pkg::*;

  logic [6:0]          func_code_q;
  logic [RegCntW-1:0]  reg_count_q;

  phase_e              phase_q, phase_d;
  logic [ByteCntW-1:0] byte_cnt_q, byte_cnt_d;
  logic [15:0]         crc_q, crc_d, crc_next;
  logic [7:0]          hold_q, hold_d;
  logic [7:0]          crc_lo_q, crc_lo_d;
  logic [15:0]         store_q [MaxRegisters];

  logic                store_we;
  logic [RegIdxW-1:0]  store_idx;
  logic                emit;
  status_e             emit_status;
  logic                drain_start;

  logic                drain_q, drain_d;
  logic [RegIdxW-1:0]  drain_idx_q, drain_idx_d;
  logic                drain_last;

  logic                out_valid_q, out_valid_d;
  logic [2:0]          status_q, status_d;
  logic [2:0]          reg_index_q, reg_index_d;
  logic [15:0]         reg_value_q, reg_value_d;
  logic                last_q, last_d;

  logic                out_free;
  logic                in_accept;
  logic [RegCntW-1:0]  n_eff;
  logic [ByteCntW:0]   k_plus1;
  logic [ByteCntW-1:0] half_k;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_code_q <= 7'd4;
      reg_count_q <= RegCntW'(4);
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_FUNC_CODE: func_code_q <= cfg_data_i[6:0];
        CFG_REG_COUNT: reg_count_q <= cfg_data_i[RegCntW-1:0];
        default: ;
      endcase
    end
  end

  // clamp register count into 1..MaxRegisters
  always_comb begin
    if (reg_count_q == '0) begin
      n_eff = RegCntW'(1);
    end else if (32'(reg_count_q) > MaxRegisters) begin
      n_eff = RegCntW'(MaxRegisters);
    end else begin
      n_eff = reg_count_q;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = drain_q || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  mrrc_crc_update u_crc (
    .crc_i  (crc_q),
    .data_i (rx_byte_i),
    .crc_o  (crc_next)
  );

  assign k_plus1 = {1'b0, byte_cnt_q} + (ByteCntW+1)'(1);
  assign half_k  = (byte_cnt_q >> 1) - ByteCntW'(1);

  always_comb begin
    phase_d     = phase_q;
    byte_cnt_d  = byte_cnt_q;
    crc_d       = crc_q;
    hold_d      = hold_q;
    crc_lo_d    = crc_lo_q;
    store_we    = 1'b0;
    store_idx   = half_k[RegIdxW-1:0];
    emit        = 1'b0;
    emit_status = ST_OK;
    drain_start = 1'b0;

    if (in_accept) begin
      case (action_e'(action_i))
        ACT_ARM: begin
          phase_d    = PH_ADDR;
          byte_cnt_d = '0;
          crc_d      = CrcInit;
        end
        ACT_TIMEOUT: begin
          if (phase_q != PH_IDLE) begin
            emit        = 1'b1;
            emit_status = (phase_q == PH_EXC) ? ST_EXC : ST_TIMEOUT;
            phase_d     = PH_IDLE;
          end
        end
        ACT_BYTE: begin
          case (phase_q)
            PH_ADDR: begin
              if (rx_byte_i != SlaveAddr) begin
                emit        = 1'b1;
                emit_status = ST_ADDR;
                phase_d     = PH_IDLE;
              end else begin
                crc_d   = crc_next;
                phase_d = PH_CODE;
              end
            end
            PH_CODE: begin
              if (rx_byte_i == {1'b0, func_code_q}) begin
                crc_d      = crc_next;
                phase_d    = PH_BODY;
                byte_cnt_d = '0;
              end else if (rx_byte_i == {1'b1, func_code_q}) begin
                phase_d    = PH_EXC;
                byte_cnt_d = '0;
              end else begin
                emit        = 1'b1;
                emit_status = ST_CODE;
                phase_d     = PH_IDLE;
              end
            end
            PH_EXC: begin
              byte_cnt_d = k_plus1[ByteCntW-1:0];
              if (k_plus1[ByteCntW-1:0] >= ExcTailBytes) begin
                emit        = 1'b1;
                emit_status = ST_EXC;
                phase_d     = PH_IDLE;
              end
            end
            PH_BODY: begin
              crc_d = crc_next;
              if (byte_cnt_q != '0) begin
                if (byte_cnt_q[0]) begin
                  hold_d = rx_byte_i;
                end else if (32'(half_k) < MaxRegisters) begin
                  store_we = 1'b1;
                end
              end
              byte_cnt_d = k_plus1[ByteCntW-1:0];
              // address, code and count bytes precede, then 2n data bytes
              if (k_plus1 >= ({2'b00, n_eff} << 1) + (ByteCntW+1)'(1)) begin
                phase_d = PH_CRCLO;
              end
            end
            PH_CRCLO: begin
              crc_lo_d = rx_byte_i;
              phase_d  = PH_CRCHI;
            end
            PH_CRCHI: begin
              phase_d = PH_IDLE;
              if ({rx_byte_i, crc_lo_q} != crc_q) begin
                emit        = 1'b1;
                emit_status = ST_CRC;
              end else begin
                drain_start = 1'b1;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      byte_cnt_q <= '0;
      crc_q      <= CrcInit;
      hold_q     <= '0;
      crc_lo_q   <= '0;
    end else begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      crc_q      <= crc_d;
      hold_q     <= hold_d;
      crc_lo_q   <= crc_lo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[store_idx] <= {hold_q, rx_byte_i};
    end
  end

  // result side: single status item or playout of the stored registers
  assign drain_last = ({1'b0, drain_idx_q} + (RegIdxW+1)'(1)) == (RegIdxW+1)'(n_eff);

  always_comb begin
    drain_d     = drain_q;
    drain_idx_d = drain_idx_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    reg_index_d = reg_index_q;
    reg_value_d = reg_value_q;
    last_d      = last_q;

    if (drain_start) begin
      drain_d     = 1'b1;
      drain_idx_d = '0;
    end

    if (out_free) begin
      out_valid_d = emit || drain_q;
      if (emit) begin
        status_d    = emit_status;
        reg_index_d = '0;
        reg_value_d = '0;
        last_d      = 1'b1;
      end else if (drain_q) begin
        status_d    = ST_OK;
        reg_index_d = 3'(drain_idx_q);
        reg_value_d = store_q[drain_idx_q];
        last_d      = drain_last;
        if (drain_last) begin
          drain_d = 1'b0;
        end else begin
          drain_idx_d = drain_idx_q + RegIdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q     <= 1'b0;
      drain_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      drain_q     <= drain_d;
      drain_idx_q <= drain_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    reg_index_q <= reg_index_d;
    reg_value_q <= reg_value_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign reg_index_o = reg_index_q;
  assign reg_value_o = reg_value_q;
  assign last_o      = last_q;

endmodule
